// ===== rtl/pipt_pkg.sv =====
// ----------------------------------------------------------------------------
// pipt_pkg
// Shared widths and opcodes of the point-in-polygon test unit.
// ----------------------------------------------------------------------------
package pipt_pkg;

    localparam int OP_W    = 2;
    localparam int COORD_W = 32;
    localparam int VTOT_W  = 7;
    // difference of two coordinates, and product of two differences
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;

    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

endpackage

// ===== rtl/point_in_polygon_test_unit.sv =====
// ----------------------------------------------------------------------------
// point_in_polygon_test_unit
// Even-odd crossing-number test against a stored polygon, one edge at a time.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------
//  input   | in_valid / in_stall  | opcode, coord_x, coord_y
//  output  | out_valid / out_stall| inside_res, vertex_total, overflowed
//
//  Append, clear and a query of an empty polygon: result loaded at accept.
//  Query of n vertices: load, first vertex, then four steps per edge (diff, mul,
//  mul, compare), both mul steps on the single 33x33 signed multiplier, then done.
//  Vertex memory reads one entry per cycle, registered.
//  rst_n clears count, overflow flag and control; vertex memory is not cleared.
//  in_stall is high during a query and while a result waits under out_stall.
// ----------------------------------------------------------------------------
module point_in_polygon_test_unit
    import pipt_pkg::*;
#(
    parameter int MAX_VERTICES = 64
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [OP_W-1:0]           opcode,
    input  logic signed [COORD_W-1:0] coord_x,
    input  logic signed [COORD_W-1:0] coord_y,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      inside_res,
    output logic [VTOT_W-1:0]         vertex_total,
    output logic                      overflowed
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_VERTICES);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD0 = 3'd1;
    localparam logic [2:0] S_FIRST = 3'd2;
    localparam logic [2:0] S_DIFF  = 3'd3;
    localparam logic [2:0] S_MUL1  = 3'd4;
    localparam logic [2:0] S_MUL2  = 3'd5;
    localparam logic [2:0] S_CMP   = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    // control
    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic          inside_reg, inside_next;
    logic          last_reg, last_next;
    logic          out_valid_reg, out_valid_next;

    // datapath
    logic signed [COORD_W-1:0] qx_reg, qx_next, qy_reg, qy_next;
    logic signed [COORD_W-1:0] first_x_reg, first_x_next, first_y_reg, first_y_next;
    logic signed [COORD_W-1:0] prev_x_reg, prev_x_next, prev_y_reg, prev_y_next;
    logic signed [COORD_W-1:0] rd_x_reg, rd_y_reg;
    logic signed [DIFF_W-1:0]  a_reg, a_next, b_reg, b_next;
    logic signed [DIFF_W-1:0]  c_reg, c_next, d_reg, d_next;
    logic                      strad_reg, strad_next;
    logic signed [PROD_W-1:0]  p1_reg, p1_next, p2_reg, p2_next;
    logic                      out_inside_reg, out_inside_next;
    logic [VTOT_W-1:0]         out_total_reg, out_total_next;
    logic                      out_ovf_reg, out_ovf_next;

    logic [COORD_W-1:0] vx_mem [MAX_VERTICES];
    logic [COORD_W-1:0] vy_mem [MAX_VERTICES];

    logic                      in_acc, out_free, wr_en, load_out, load_inside, closing;
    logic [CW+VTOT_W-1:0]      tot_ext;
    logic signed [COORD_W-1:0] cur_x, cur_y;
    logic signed [DIFF_W-1:0]  dx_q, dx_e, dy, ry;
    logic signed [DIFF_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0]  mul_p;

    assign in_stall = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // current edge: prev -> cur, closing edge returns to the first vertex
    assign closing = (idx_reg == count_reg);
    assign cur_x   = closing ? first_x_reg : rd_x_reg;
    assign cur_y   = closing ? first_y_reg : rd_y_reg;
    assign dx_q    = {qx_reg[COORD_W-1], qx_reg} - {prev_x_reg[COORD_W-1], prev_x_reg};
    assign dx_e    = {cur_x[COORD_W-1], cur_x} - {prev_x_reg[COORD_W-1], prev_x_reg};
    assign dy      = {cur_y[COORD_W-1], cur_y} - {prev_y_reg[COORD_W-1], prev_y_reg};
    assign ry      = {qy_reg[COORD_W-1], qy_reg} - {prev_y_reg[COORD_W-1], prev_y_reg};

    // shared multiplier
    assign mul_a = (state_reg == S_MUL2) ? c_reg : a_reg;
    assign mul_b = (state_reg == S_MUL2) ? d_reg : b_reg;
    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        inside_next     = inside_reg;
        last_next       = last_reg;
        out_valid_next  = out_valid_reg;
        qx_next         = qx_reg;
        qy_next         = qy_reg;
        first_x_next    = first_x_reg;
        first_y_next    = first_y_reg;
        prev_x_next     = prev_x_reg;
        prev_y_next     = prev_y_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        c_next          = c_reg;
        d_next          = d_reg;
        strad_next      = strad_reg;
        p1_next         = p1_reg;
        p2_next         = p2_reg;
        out_inside_next = out_inside_reg;
        out_total_next  = out_total_reg;
        out_ovf_next    = out_ovf_reg;
        wr_en           = 1'b0;
        load_out        = 1'b0;
        load_inside     = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (opcode)
                        OP_APPEND:
                        begin
                            if (count_reg < MAX_CNT)
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                            load_out = 1'b1;
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                            ovf_next   = 1'b0;
                            load_out   = 1'b1;
                        end
                        OP_QUERY:
                        begin
                            qx_next = coord_x;
                            qy_next = coord_y;
                            if (count_reg == '0)
                            begin
                                load_out = 1'b1;
                            end
                            else
                            begin
                                idx_next    = '0;
                                inside_next = 1'b0;
                                state_next  = S_LOAD0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_LOAD0:
            begin
                idx_next   = CW'(1);
                state_next = S_FIRST;
            end
            S_FIRST:
            begin
                first_x_next = rd_x_reg;
                first_y_next = rd_y_reg;
                prev_x_next  = rd_x_reg;
                prev_y_next  = rd_y_reg;
                state_next   = S_DIFF;
            end
            S_DIFF:
            begin
                // straddle implies a non-horizontal edge
                strad_next  = (prev_y_reg > qy_reg) != (cur_y > qy_reg);
                a_next      = dx_q;
                c_next      = dx_e;
                b_next      = dy[DIFF_W-1] ? -dy : dy;
                d_next      = dy[DIFF_W-1] ? -ry : ry;
                last_next   = closing;
                prev_x_next = cur_x;
                prev_y_next = cur_y;
                idx_next    = idx_reg + 1'b1;
                state_next  = S_MUL1;
            end
            S_MUL1:
            begin
                p1_next    = mul_p;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                p2_next    = mul_p;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (strad_reg && (p1_reg < p2_reg))
                begin
                    inside_next = !inside_reg;
                end
                state_next = last_reg ? S_DONE : S_DIFF;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    load_out    = 1'b1;
                    load_inside = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        tot_ext = {{VTOT_W{1'b0}}, count_next};
        if (load_out)
        begin
            out_valid_next  = 1'b1;
            out_inside_next = load_inside && inside_reg;
            out_total_next  = tot_ext[VTOT_W-1:0];
            out_ovf_next    = ovf_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            inside_reg    <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            inside_reg    <= inside_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qx_reg         <= qx_next;
        qy_reg         <= qy_next;
        first_x_reg    <= first_x_next;
        first_y_reg    <= first_y_next;
        prev_x_reg     <= prev_x_next;
        prev_y_reg     <= prev_y_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        c_reg          <= c_next;
        d_reg          <= d_next;
        strad_reg      <= strad_next;
        p1_reg         <= p1_next;
        p2_reg         <= p2_next;
        out_inside_reg <= out_inside_next;
        out_total_reg  <= out_total_next;
        out_ovf_reg    <= out_ovf_next;
    end

    // vertex memory: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            vx_mem[count_reg[AW-1:0]] <= coord_x;
            vy_mem[count_reg[AW-1:0]] <= coord_y;
        end
        rd_x_reg <= vx_mem[idx_reg[AW-1:0]];
        rd_y_reg <= vy_mem[idx_reg[AW-1:0]];
    end

    assign out_valid    = out_valid_reg;
    assign inside_res   = out_inside_reg;
    assign vertex_total = out_total_reg;
    assign overflowed   = out_ovf_reg;

endmodule

// ===== rtl/pipt_checker.sv =====
// ----------------------------------------------------------------------------
// pipt_checker
// Port-level checks of the point-in-polygon test unit, bound to the top level.
// ----------------------------------------------------------------------------
module pipt_checker
    import pipt_pkg::*;
#(
    parameter int MAX_VERTICES = 64
)
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_stall,
    input logic [OP_W-1:0]           opcode,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic                      inside_res,
    input logic [VTOT_W-1:0]         vertex_total,
    input logic                      overflowed
);

    localparam logic [VTOT_W-1:0] MAX_TOT = VTOT_W'(MAX_VERTICES);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(inside_res)
            && $stable(vertex_total) && $stable(overflowed))
        else $error("output transaction changed while stalled");

    // overflow is only possible with a full store, and sticks until clear
    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflowed |-> vertex_total == MAX_TOT)
        else $error("overflow flagged with store not full");

    a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> int'(vertex_total) <= MAX_VERTICES)
        else $error("vertex total beyond capacity");

    // a clear answers in the next cycle with an empty, clean polygon
    a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && opcode == OP_CLEAR |=>
            out_valid && vertex_total == '0 && !overflowed && !inside_res)
        else $error("clear transaction gave wrong result");

endmodule

bind point_in_polygon_test_unit pipt_checker #(.MAX_VERTICES(MAX_VERTICES)) u_pipt_checker (.*);
